>>> sv/pkfb_pkg.sv
// Package: shared types, codes and constants of the packed-pixel framebuffer.
package pkfb_pkg;

  // Fixed field widths
  localparam int COORD_W  = 13;   // holds 0..4095, the largest frame bound
  localparam int COLOR_W  = 32;
  localparam int CFG_W    = 14;   // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int BA_W     = 27;   // unwrapped byte address
  localparam int QDEPTH   = 4;

  // Defaults for top-level parameters
  localparam int DEF_MEM_WORDS = 262144;
  localparam int DEF_MAX_DIM   = 2048;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  // Pixel formats
  localparam logic [2:0] FMT_4  = 3'd0;
  localparam logic [2:0] FMT_8  = 3'd1;
  localparam logic [2:0] FMT_16 = 3'd2;
  localparam logic [2:0] FMT_24 = 3'd3;
  localparam logic [2:0] FMT_32 = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

  // Command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_FILL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 hit;
    logic [COORD_W-1:0]   x0;
    logic [COORD_W-1:0]   y0;
    logic [COORD_W-1:0]   x1;
    logic [COORD_W-1:0]   y1;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  // Configuration seen by front and back
  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [13:0] line_bytes;
    logic [2:0]  pixel_format;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_RED,
    B_ACC0,
    B_ACC1,
    B_RD,
    B_DONE
  } bstate_t;

endpackage

>>> sv/pkfb_ifs.sv
// Interfaces: pixel command channel and result channel.
interface pkfb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [11:0] rect_width;
  logic signed [11:0] rect_height;
  logic [31:0]        pixel_color;
  modport source (output valid, op, pos_x, pos_y, rect_width, rect_height, pixel_color,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, rect_width, rect_height, pixel_color,
                output ready);
endinterface

interface pkfb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_color;
  logic        hit;
  modport source (output valid, read_color, hit, input ready);
  modport sink (input valid, read_color, hit, output ready);
endinterface

>>> sv/pkfb_front.sv
// Front end: accepts words, clips against the frame and forms back-end commands.
module pkfb_front #(
  parameter int MAX_DIM = pkfb_pkg::DEF_MAX_DIM
) (
  pkfb_in_if.sink         pix_in,
  input  pkfb_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output pkfb_pkg::cmd_t  q_cmd
);
  import pkfb_pkg::*;

  logic signed [13:0] sx, sy, sw, sh, fw, fh;
  logic signed [13:0] x0s, y0s, xe, ye, x1s, y1s;
  logic               fmt_ok, in_frame, fill_ok;

  assign pix_in.ready = !q_full;
  assign q_push       = pix_in.valid && !q_full;

  // Frame bounds saturate to the largest supported size
  always_comb begin
    fw = (cfg.frame_width > 12'(MAX_DIM) && MAX_DIM < 4096) ? 14'(MAX_DIM)
         : {2'b00, cfg.frame_width};
    fh = (cfg.frame_height > 12'(MAX_DIM) && MAX_DIM < 4096) ? 14'(MAX_DIM)
         : {2'b00, cfg.frame_height};
  end

  // Clipping
  always_comb begin
    sx = 14'(pix_in.pos_x);
    sy = 14'(pix_in.pos_y);
    sw = 14'(pix_in.rect_width);
    sh = 14'(pix_in.rect_height);
    fmt_ok   = cfg.pixel_format <= FMT_32;
    in_frame = (sx >= 0) && (sx < fw) && (sy >= 0) && (sy < fh);
    x0s = (sx < 0) ? 14'sd0 : sx;
    y0s = (sy < 0) ? 14'sd0 : sy;
    xe  = sx + sw;
    ye  = sy + sh;
    x1s = (xe > fw) ? fw : xe;
    y1s = (ye > fh) ? fh : ye;
    fill_ok = (sw > 0) && (sh > 0) && (x0s < x1s) && (y0s < y1s);
  end

  // Classification
  always_comb begin
    q_cmd.kind  = CMD_NONE;
    q_cmd.hit   = 1'b0;
    q_cmd.x0    = COORD_W'(sx);
    q_cmd.y0    = COORD_W'(sy);
    q_cmd.x1    = COORD_W'(sx + 14'sd1);
    q_cmd.y1    = COORD_W'(sy + 14'sd1);
    q_cmd.color = pix_in.pixel_color;
    if (fmt_ok) begin
      unique case (pix_in.op)
        OP_WRITE: begin
          if (in_frame) begin
            q_cmd.kind = CMD_FILL;
            q_cmd.hit  = 1'b1;
          end
        end
        OP_READ: begin
          if (in_frame) begin
            q_cmd.kind = CMD_READ;
            q_cmd.hit  = 1'b1;
          end
        end
        OP_FILL: begin
          q_cmd.x0 = COORD_W'(x0s);
          q_cmd.y0 = COORD_W'(y0s);
          q_cmd.x1 = COORD_W'(x1s);
          q_cmd.y1 = COORD_W'(y1s);
          if (fill_ok) begin
            q_cmd.kind = CMD_FILL;
            q_cmd.hit  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pkfb_fifo.sv
// Command queue between front and back end.
module pkfb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pkfb_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pkfb_pkg::cmd_t  head
);
  import pkfb_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t            slots [QDEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [PW:0]     count;

  assign full  = count == (PW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QDEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("push lost");
`endif

endmodule

>>> sv/pkfb_back.sv
// Back end: pixel address sequencer, frame memory and result register.
module pkfb_back #(
  parameter int MEM_WORDS = pkfb_pkg::DEF_MEM_WORDS
) (
  input  logic            clk,
  input  logic            rst,
  input  pkfb_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  pkfb_pkg::cmd_t  q_head,
  output logic            q_pop,
  pkfb_out_if.source      pix_out
);
  import pkfb_pkg::*;

  localparam int  WA_W  = $clog2(MEM_WORDS);
  localparam int  BW_W  = WA_W + 2;
  localparam bit  POW2  = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam int  RED_K = BA_W - BW_W;
  localparam int  RK_W  = $clog2(RED_K + 1);
  localparam logic [BA_W:0] M_BYTES = (BA_W+1)'(4 * MEM_WORDS);

  bstate_t            st, st_next;
  cmd_t               cur;
  logic [COORD_W-1:0] x, y;
  logic [BA_W-1:0]    prod, addr;
  logic [RK_W-1:0]    rk;
  logic [31:0]        mem [MEM_WORDS];
  logic [31:0]        mem_q, rdata0, res_color;
  logic               ov;
  logic [31:0]        ov_color;
  logic               ov_hit;

  logic [COORD_W+1:0] xoff;
  logic [1:0]         o;
  logic [WA_W-1:0]    w0, w1, raddr;
  logic [2:0]         nbytes;
  logic [7:0]         bmask;
  logic [15:0]        nmask;
  logic [63:0]        wd64, rd64;
  logic [31:0]        rd_color;
  logic               we;
  logic [WA_W-1:0]    waddr;
  logic [7:0]         wen;
  logic [31:0]        wdata;
  logic               last_px, out_free;
  logic [BA_W:0]      m_sh;

  assign out_free = !ov || pix_out.ready;
  assign last_px  = (x + 1'b1 == cur.x1) && (y + 1'b1 == cur.y1);
  assign m_sh     = M_BYTES << rk;

  // Byte offset of the pixel within its line
  always_comb begin
    unique case (cfg.pixel_format)
      FMT_4:   xoff = (COORD_W+2)'(x >> 1);
      FMT_8:   xoff = (COORD_W+2)'(x);
      FMT_16:  xoff = (COORD_W+2)'({x, 1'b0});
      FMT_24:  xoff = (COORD_W+2)'({x, 1'b0}) + (COORD_W+2)'(x);
      default: xoff = (COORD_W+2)'({x, 2'b00});
    endcase
  end

  // Pixel lane geometry
  always_comb begin
    o  = addr[1:0];
    w0 = addr[BW_W-1:2];
    w1 = (w0 == WA_W'(MEM_WORDS - 1)) ? '0 : w0 + 1'b1;
    unique case (cfg.pixel_format)
      FMT_8:   nbytes = 3'd1;
      FMT_16:  nbytes = 3'd2;
      FMT_24:  nbytes = 3'd3;
      default: nbytes = 3'd4;
    endcase
    bmask = ((8'h01 << nbytes) - 8'h01) << o;
    for (int i = 0; i < 8; i++) begin
      nmask[2*i]   = bmask[i];
      nmask[2*i+1] = bmask[i];
    end
    wd64 = {32'h0, cur.color} << {o, 3'b000};
    if (cfg.pixel_format == FMT_4) begin
      nmask = 16'h0001 << {o, x[0]};
      wd64  = {16{cur.color[7:4]}};
    end
  end

  // Read-back extraction
  always_comb begin
    rd64 = {mem_q, rdata0} >> {o, 3'b000};
    unique case (cfg.pixel_format)
      FMT_4:   rd_color = x[0] ? {24'h0, rd64[7:4], 4'h0} : {24'h0, rd64[3:0], 4'h0};
      FMT_8:   rd_color = {24'h0, rd64[7:0]};
      FMT_16:  rd_color = {16'h0, rd64[15:0]};
      FMT_24:  rd_color = {8'h0, rd64[23:0]};
      default: rd_color = rd64[31:0];
    endcase
  end

  // Memory port control
  always_comb begin
    raddr = (st == B_ACC1) ? w1 : w0;
    waddr = (st == B_ACC1) ? w1 : w0;
    wen   = (st == B_ACC1) ? nmask[15:8] : nmask[7:0];
    wdata = (st == B_ACC1) ? wd64[63:32] : wd64[31:0];
    we    = (cur.kind == CMD_FILL) && (st == B_ACC0 || st == B_ACC1) && (|wen);
  end

  // Frame memory, nibble write enables, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < 8; i++) begin
        if (wen[i]) mem[waddr][4*i +: 4] <= wdata[4*i +: 4];
      end
    end
    mem_q <= mem[raddr];
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      B_IDLE: if (!q_empty) st_next = (q_head.kind == CMD_NONE) ? B_DONE : B_MUL;
      B_MUL:  st_next = B_ADD;
      B_ADD:  st_next = POW2 ? B_ACC0 : B_RED;
      B_RED:  if (rk == '0) st_next = B_ACC0;
      B_ACC0: st_next = B_ACC1;
      B_ACC1: begin
        if (cur.kind == CMD_READ) st_next = B_RD;
        else st_next = last_px ? B_DONE : B_MUL;
      end
      B_RD:   st_next = B_DONE;
      B_DONE: if (out_free) st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  assign q_pop = (st == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else     st <= st_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (st)
      B_IDLE: begin
        cur       <= q_head;
        x         <= q_head.x0;
        y         <= q_head.y0;
        res_color <= '0;
      end
      B_MUL:  prod <= BA_W'(y * cfg.line_bytes);
      B_ADD: begin
        addr <= prod + BA_W'(xoff);
        rk   <= RK_W'(RED_K);
      end
      B_RED: begin
        if ({1'b0, addr} >= m_sh) addr <= BA_W'({1'b0, addr} - m_sh);
        rk <= rk - 1'b1;
      end
      B_ACC1: begin
        rdata0 <= mem_q;
        if (cur.kind == CMD_FILL) begin
          if (x + 1'b1 == cur.x1) begin
            x <= cur.x0;
            y <= y + 1'b1;
          end else begin
            x <= x + 1'b1;
          end
        end
      end
      B_RD:   res_color <= rd_color;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (st == B_DONE && out_free) begin
      ov <= 1'b1;
    end else if (pix_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_DONE && out_free) begin
      ov_color <= res_color;
      ov_hit   <= cur.hit;
    end
  end

  assign pix_out.valid      = ov;
  assign pix_out.read_color = ov_color;
  assign pix_out.hit        = ov_hit;

endmodule

>>> sv/packed_pixel_framebuffer_core.sv
// Top level: packed-pixel framebuffer with pixel write, pixel read and rectangle fill.
//
// pix_in carries one command word (op, origin, size, color); pix_out returns one
// result word (read_color, hit) per command, in order. Both use valid/ready.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block does not enforce this. The front end clips each command and
// queues it (four entries); the back end walks pixels through one multiplier for
// the line address and a single frame memory with one write and one registered read
// port. Back-end sequencer states per command: a pixel write runs MUL, ADD, ACC0, ACC1
// and DONE; a pixel read adds RD before DONE; a no-op or miss goes straight to DONE;
// a fill repeats MUL through ACC1 for each pixel, then goes to DONE. When MEM_WORDS is
// not a power of two, each pixel also passes through the address-wrap state B_RED.
// A command passes through the queue, then the back end, then the result register.
// A stalled receiver holds the result register; the queue keeps taking commands
// until it is full, then pix_in.ready drops.
// Reset (rst, synchronous) empties the queue and result register and restores
// 320x240, 640-byte lines, 16-bit pixels. Frame memory is not cleared.
module packed_pixel_framebuffer_core #(
  parameter int MEM_WORDS = pkfb_pkg::DEF_MEM_WORDS,
  parameter int MAX_DIM   = pkfb_pkg::DEF_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  pkfb_in_if.sink                         pix_in,
  pkfb_out_if.source                      pix_out,
  input  logic                            cfg_we,
  input  logic [pkfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pkfb_pkg::CFG_W-1:0]      cfg_data
);
  import pkfb_pkg::*;

  cfg_t cfg;
  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_cmd, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 12'd320;
      cfg.frame_height <= 12'd240;
      cfg.line_bytes   <= 14'd640;
      cfg.pixel_format <= FMT_16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[11:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[11:0];
        REG_LINE_BYTES:   cfg.line_bytes   <= cfg_data[13:0];
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pkfb_front #(.MAX_DIM(MAX_DIM)) u_front (
    .pix_in (pix_in),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  pkfb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pkfb_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pix_out (pix_out)
  );

endmodule

>>> bench/packed_pixel_framebuffer_core_tb.sv
// Testbench: random and directed pixel writes, reads and fills, checked against a built-in framebuffer model.
module packed_pixel_framebuffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pkfb_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;   // undefined op, must answer 0, 0
  localparam int ADDR_MASK = 4 * DEF_MEM_WORDS - 1;
  localparam int STALL_LIMIT = 20000;

  // Framebuffer predictor: registers, byte memory with nibble-written marks, pending results
  class fb_scoreboard;
    typedef struct {
      logic [31:0] color;
      logic        hit;
    } pix_result_t;

    int unsigned fb_width = 320, fb_height = 240, fb_stride = 640, fb_fmt = 2;
    logic [7:0]  mem_byte[int];
    logic [1:0]  mem_known[int];
    pix_result_t pending_q[$];
    int          errors;

    function void set_reg(int idx, int unsigned val);
      case (idx)
        REG_FRAME_WIDTH:  fb_width  = val & 12'hFFF;
        REG_FRAME_HEIGHT: fb_height = val & 12'hFFF;
        REG_LINE_BYTES:   fb_stride = val & 14'h3FFF;
        default:          fb_fmt    = val & 3'h7;
      endcase
    endfunction

    function int eff_w();
      return (fb_width > DEF_MAX_DIM) ? DEF_MAX_DIM : fb_width;
    endfunction

    function int eff_h();
      return (fb_height > DEF_MAX_DIM) ? DEF_MAX_DIM : fb_height;
    endfunction

    function int bpp();
      case (fb_fmt)
        FMT_4:   return 4;
        FMT_8:   return 8;
        FMT_16:  return 16;
        FMT_24:  return 24;
        FMT_32:  return 32;
        default: return 0;
      endcase
    endfunction

    function bit in_frame(int x, int y);
      return bpp() != 0 && x >= 0 && x < eff_w() && y >= 0 && y < eff_h();
    endfunction

    function int byte_addr(int x, int y, int i);
      int unsigned a;
      a = y * fb_stride + ((x * bpp()) >> 3) + i;
      return a & ADDR_MASK;
    endfunction

    function logic [7:0] get_b(int a);
      return mem_byte.exists(a) ? mem_byte[a] : 8'h00;
    endfunction

    function void put_px(int x, int y, logic [31:0] c);
      int a;
      logic [7:0] b;
      a = byte_addr(x, y, 0);
      if (bpp() == 4) begin
        b = get_b(a);
        if (!mem_known.exists(a)) mem_known[a] = 2'b00;
        if (x & 1) begin
          b[7:4] = c[7:4];
          mem_known[a][1] = 1'b1;
        end else begin
          b[3:0] = c[7:4];
          mem_known[a][0] = 1'b1;
        end
        mem_byte[a] = b;
      end else begin
        for (int i = 0; i < bpp() / 8; i++) begin
          a = byte_addr(x, y, i);
          mem_byte[a] = c[8*i +: 8];
          mem_known[a] = 2'b11;
        end
      end
    endfunction

    function logic [31:0] get_px(int x, int y);
      logic [31:0] c;
      logic [7:0] b;
      c = '0;
      b = get_b(byte_addr(x, y, 0));
      if (bpp() == 4) return (x & 1) ? {24'h0, b[7:4], 4'h0} : {24'h0, b[3:0], 4'h0};
      for (int i = 0; i < bpp() / 8; i++) c[8*i +: 8] = get_b(byte_addr(x, y, i));
      return c;
    endfunction

    // True unless the read would touch a pixel never written
    function bit readable(int x, int y);
      int a;
      if (!in_frame(x, y)) return 1;
      a = byte_addr(x, y, 0);
      if (bpp() == 4) return mem_known.exists(a) && mem_known[a][(x & 1) ? 1 : 0];
      for (int i = 0; i < bpp() / 8; i++) begin
        a = byte_addr(x, y, i);
        if (!mem_known.exists(a) || mem_known[a] != 2'b11) return 0;
      end
      return 1;
    endfunction

    // Clipped fill area in pixels
    function int fill_area(int px, int py, int rw, int rh);
      int x0, y0, x1, y1;
      if (bpp() == 0 || rw <= 0 || rh <= 0) return 0;
      x0 = px < 0 ? 0 : px;
      y0 = py < 0 ? 0 : py;
      x1 = px + rw > eff_w() ? eff_w() : px + rw;
      y1 = py + rh > eff_h() ? eff_h() : py + rh;
      return (x0 < x1 && y0 < y1) ? (x1 - x0) * (y1 - y0) : 0;
    endfunction

    function void note_cmd(logic [1:0] op, int px, int py, int rw, int rh, logic [31:0] c);
      pix_result_t r;
      r.color = '0;
      r.hit = 1'b0;
      if (op == OP_WRITE || op == OP_READ) begin
        if (in_frame(px, py)) begin
          r.hit = 1'b1;
          if (op == OP_WRITE) put_px(px, py, c);
          else r.color = get_px(px, py);
        end
      end else if (op == OP_FILL && fill_area(px, py, rw, rh) > 0) begin
        r.hit = 1'b1;
        for (int y = (py < 0 ? 0 : py); y < py + rh && y < eff_h(); y++)
          for (int x = (px < 0 ? 0 : px); x < px + rw && x < eff_w(); x++)
            put_px(x, y, c);
      end
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] color, logic hit);
      pix_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word color=%h hit=%b", color, hit));
      end else begin
        r = pending_q.pop_front();
        if (color !== r.color)
          report($sformatf("read_color %h, predicted %h", color, r.color));
        if (hit !== r.hit)
          report($sformatf("hit %b, predicted %b", hit, r.hit));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  bit steady = 0;       // no idling on either side while set
  int stall_count = 0;
  fb_scoreboard sb = new();

  pkfb_in_if pin();
  pkfb_out_if pout();

  packed_pixel_framebuffer_core dut (
    .clk(clk), .rst(rst), .pix_in(pin.sink), .pix_out(pout.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    pin.valid = 1'b0;
    pin.op = '0;
    pin.pos_x = '0;
    pin.pos_y = '0;
    pin.rect_width = '0;
    pin.rect_height = '0;
    pin.pixel_color = '0;
    pout.ready = 1'b0;
  end

  // Result side: check accepted words, stall at random, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (pout.valid && pout.ready) sb.check_result(pout.read_color, pout.hit);
      pout.ready <= steady || ($urandom_range(99) >= 37);
      if ((pout.valid && pout.ready) || (pin.valid && pin.ready)) stall_count <= 0;
      else if (stall_count >= STALL_LIMIT) begin
        $display("packed_pixel_framebuffer_core_tb: done, errors");
        $finish;
      end else stall_count <= stall_count + 1;
    end
  end

  // Send one command word and wait for its handshake
  task automatic send_cmd(logic [1:0] op, int px, int py, int rw, int rh, logic [31:0] c);
    while (!steady && $urandom_range(99) < 37) begin
      pin.valid <= 1'b0;
      @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.op <= op;
    pin.pos_x <= px[11:0];
    pin.pos_y <= py[11:0];
    pin.rect_width <= rw[11:0];
    pin.rect_height <= rh[11:0];
    pin.pixel_color <= c;
    do @(posedge clk); while (!pin.ready);
    sb.note_cmd(op, px, py, rw, rh, c);
  endtask

  task automatic drain();
    pin.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int lb, int fmt);
    int vals[4];
    vals = '{w, h, lb, fmt};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i][CFG_W-1:0];
      sb.set_reg(i, vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // seed the top-left corner so reads have known pixels
    send_cmd(OP_FILL, 0, 0, 32, 16, $urandom);
  endtask

  function automatic int pick_coord(int dim);
    int lim;
    lim = dim > 48 ? 48 : dim;
    if ($urandom_range(4) == 0) return int'($urandom_range(4095)) - 2048;
    return int'($urandom_range(lim + 7)) - 4;
  endfunction

  task automatic random_cmds(int n);
    int r, px, py, rw, rh;
    logic [1:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      px = pick_coord(sb.eff_w());
      py = pick_coord(sb.eff_h());
      rw = int'($urandom_range(4095)) - 2048;
      rh = int'($urandom_range(4095)) - 2048;
      if (r < 35) op = OP_WRITE;
      else if (r < 72) op = OP_READ;
      else if (r < 92) op = OP_FILL;
      else op = OP_SPARE;
      if (op == OP_READ) begin
        for (int t = 0; t < 8 && !sb.readable(px, py); t++) begin
          px = $urandom_range(31);
          py = $urandom_range(15);
        end
        if (!sb.readable(px, py)) px = -1 - int'($urandom_range(2047));
      end
      if (op == OP_FILL) begin
        if ($urandom_range(3) != 0) begin
          rw = int'($urandom_range(15)) - 3;
          rh = int'($urandom_range(15)) - 3;
        end
        while (sb.fill_area(px, py, rw, rh) > 512) begin
          rh = int'($urandom_range(3)) + 1;
          rw = int'($urandom_range(20)) + 1;
        end
      end
      send_cmd(op, px, py, rw, rh, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, clipping, empty and undefined cases at reset setup
    send_cmd(OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_cmd(OP_READ, 0, 0, 0, 0, 32'h0);
    send_cmd(OP_WRITE, 319, 239, 0, 0, 32'hA5A5_5A5A);
    send_cmd(OP_READ, 319, 239, 0, 0, 32'h0);
    send_cmd(OP_WRITE, 320, 0, 0, 0, 32'h1234_5678);
    send_cmd(OP_READ, -1, 5, 0, 0, 32'h0);
    send_cmd(OP_WRITE, -2048, 2047, 0, 0, 32'hFFFF_FFFF);
    send_cmd(OP_READ, 2047, -2048, 0, 0, 32'h0);
    send_cmd(OP_FILL, -5, -5, 10, 10, 32'h0000_BEEF);
    send_cmd(OP_READ, 4, 4, 0, 0, 32'h0);
    send_cmd(OP_FILL, 310, 230, 2047, 2047, 32'hFFFF_0000);
    send_cmd(OP_READ, 319, 239, 0, 0, 32'h0);
    send_cmd(OP_FILL, 0, 0, 0, 5, 32'h0);
    send_cmd(OP_FILL, 0, 0, -2048, 5, 32'h0);
    send_cmd(OP_FILL, 0, 0, 5, -1, 32'h0);
    send_cmd(OP_FILL, 320, 0, 5, 5, 32'hFFFF_FFFF);
    send_cmd(OP_FILL, -2048, -2048, 2047, 2047, 32'hFFFF_FFFF);
    send_cmd(OP_SPARE, 1, 1, 1, 1, 32'hFFFF_FFFF);
    send_cmd(OP_READ, 2, 2, 0, 0, 32'h0);

    random_cmds(80);
    set_frame(40, 20, 20, FMT_4);
    random_cmds(110);
    set_frame(33, 17, 34, FMT_8);
    random_cmds(100);
    steady = 1;
    set_frame(24, 12, 48, FMT_16);
    random_cmds(100);
    steady = 0;
    set_frame(20, 10, 60, FMT_24);
    random_cmds(100);
    set_frame(16, 8, 64, FMT_32);
    random_cmds(100);
    set_frame(4095, 4095, 8192, FMT_32);
    random_cmds(110);
    set_frame(2048, 2048, 8191, FMT_24);
    random_cmds(100);
    set_frame(1, 1, 1, FMT_4);
    random_cmds(60);
    set_frame(0, 5, 16, FMT_16);
    random_cmds(40);
    set_frame(8, 8, 16, 5);
    random_cmds(40);
    set_frame(8, 8, 16, 7);
    random_cmds(40);
    set_frame(300, 200, 1, FMT_8);
    random_cmds(100);
    set_frame(64, 32, 128, FMT_16);
    random_cmds(110);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("packed_pixel_framebuffer_core_tb: done, clean");
    end else begin
      $display("packed_pixel_framebuffer_core_tb: done, errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/pkfb_pkg.sv
sv/pkfb_ifs.sv
sv/pkfb_front.sv
sv/pkfb_fifo.sv
sv/pkfb_back.sv
sv/packed_pixel_framebuffer_core.sv
bench/packed_pixel_framebuffer_core_tb.sv
